/* design/box_blur_3x3_edge_aware_top_macros.svh */
// Assertion macros shared by the checker.
`ifndef BOX_BLUR_3X3_EDGE_AWARE_TOP_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_TOP_MACROS_SVH

// Same-cycle implication.
`define BB3_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BB3_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/bb3_pkg.sv */
`default_nettype none
package bb3_pkg;
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int RST_WIDTH      = 640;
	localparam int RST_HEIGHT     = 480;
	localparam int CFG_DATA_W     = 13;
	localparam int CFG_IDX_W      = 2;
	localparam int FIFO_DEPTH     = 8;
	localparam int PIX_W          = 24;
	localparam int SUM_W          = 12;

	// Scaled reciprocals: floor(x/12) and floor(x/18) for x below 8192.
	localparam logic [12:0] RECIP_12 = 13'd5462;
	localparam logic [12:0] RECIP_18 = 13'd3641;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1
	} cfg_reg_t;

	typedef enum logic {
		OP_PUSH  = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		CNT4 = 2'd0,
		CNT6 = 2'd1,
		CNT9 = 2'd2
	} cnt_t;

	typedef struct packed {
		logic emit;
		logic last;
		logic top;
		logic bottom;
		logic left;
		logic right;
	} tag_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} res_t;

	function automatic logic [7:0] bb3_mean(input logic [SUM_W-1:0] s, input cnt_t c);
		logic [12:0] x;
		logic [25:0] prod;
		logic [7:0]  m;
		x = {s, 1'b0};
		prod = '0;
		unique case (c)
			CNT4: begin
				x = x + 13'd4;
				m = x[10:3];
			end
			CNT6: begin
				x = x + 13'd6;
				prod = x * RECIP_12;
				m = prod[23:16];
			end
			CNT9: begin
				x = x + 13'd9;
				prod = x * RECIP_18;
				m = prod[23:16];
			end
			default: m = '0;
		endcase
		return m;
	endfunction
endpackage
`default_nettype wire

/* design/box_blur_3x3_edge_aware_top.sv */
`default_nettype none
// Channel  Handshake             Payload
// in       in_valid / in_ready   operation, red_in, green_in, blue_in
// out      out_valid / out_ready red_out, green_out, blue_out, frame_last
// cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One input transaction per cycle while in_ready is high; a result is formed
// from the transaction that causes it by the line buffer read, window update,
// sum and mean stages. Results queue in an 8-entry output FIFO; input stalls
// only when 8 results are pending. cfg_ready is always high.
// Reset clears positions, window and FIFO; line buffer contents are kept.
module box_blur_3x3_edge_aware_top import bb3_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire                  operation,
	input  wire [7:0]            red_in,
	input  wire [7:0]            green_in,
	input  wire [7:0]            blue_in,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [7:0]           red_out,
	output logic [7:0]           green_out,
	output logic [7:0]           blue_out,
	output logic                 frame_last,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [CFG_DATA_W-1:0] cfg_data
);
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH+1);
	localparam int HW = $clog2(MAX_HEIGHT+1);
	localparam int CW = $clog2(FIFO_DEPTH+1);
	localparam int W_RST = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
	localparam int H_RST = (RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT;

	logic [WW-1:0]      w_q, w_clamp;
	logic [HW-1:0]      h_q, h_clamp;
	logic [31:0]        wv, hv;
	logic               cfg_wr, restart;
	logic               accept, act, blank;
	logic [AW-1:0]      addr, mem_waddr;
	tag_t               tag;
	logic [PIX_W-1:0]   pixel;
	logic               mem_wen;
	logic [2*PIX_W-1:0] mem_wdata, mem_rdata;
	logic               push, pop;
	res_t               push_data, head;
	logic [CW-1:0]      pend_q;

	// Clamp register writes to the legal frame size.
	always_comb begin
		wv = 32'(cfg_data[10:0]);
		hv = 32'(cfg_data[12:0]);
		w_clamp = (wv < 32'd2) ? WW'(2) : (wv > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(wv);
		h_clamp = (hv < 32'd2) ? HW'(2) : (hv > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(hv);
	end

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign restart   = cfg_wr && ((cfg_index == REG_FRAME_WIDTH) ||
		(cfg_index == REG_FRAME_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WW'(W_RST);
			h_q <= HW'(H_RST);
		end else if (cfg_wr) begin
			if (cfg_index == REG_FRAME_WIDTH) begin
				w_q <= w_clamp;
			end
			if (cfg_index == REG_FRAME_HEIGHT) begin
				h_q <= h_clamp;
			end
		end
	end

	// Track results owed: count at acceptance, release on the output transaction.
	assign in_ready = pend_q < CW'(FIFO_DEPTH);
	assign accept   = in_valid && in_ready;
	assign pop      = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + CW'(act && tag.emit) - CW'(pop);
		end
	end

	// Drop pixel values once the frame is complete: they act as flushes.
	assign pixel = blank ? '0 : {red_in, green_in, blue_in};

	bb3_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.operation (operation),
		.restart   (restart),
		.w         (w_q),
		.h         (h_q),
		.act       (act),
		.blank     (blank),
		.addr      (addr),
		.tag       (tag)
	);

	bb3_line_buf #(.MAX_WIDTH(MAX_WIDTH)) u_line_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.ren    (act),
		.raddr  (addr),
		.wen    (mem_wen),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.rdata  (mem_rdata)
	);

	bb3_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.act       (act),
		.addr      (addr),
		.tag       (tag),
		.pixel     (pixel),
		.mem_rdata (mem_rdata),
		.mem_wen   (mem_wen),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.push      (push),
		.push_data (push_data)
	);

	bb3_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.valid     (out_valid),
		.head      (head)
	);

	assign red_out    = head.red;
	assign green_out  = head.green;
	assign blue_out   = head.blue;
	assign frame_last = head.last;
endmodule
`default_nettype wire

/* design/bb3_line_buf.sv */
`default_nettype none
module bb3_line_buf import bb3_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         ren,
	input  wire [$clog2(MAX_WIDTH)-1:0] raddr,
	input  wire                         wen,
	input  wire [$clog2(MAX_WIDTH)-1:0] waddr,
	input  wire [2*PIX_W-1:0]           wdata,
	output logic [2*PIX_W-1:0]          rdata
);
	// Each entry holds {upper row pixel, middle row pixel} of one column.
	logic [2*PIX_W-1:0] mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] rd_q;
	logic [2*PIX_W-1:0] fwd_q;
	logic               hit_q;

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		if (ren) begin
			rd_q  <= mem[raddr];
			fwd_q <= wdata;
		end
	end

	// Forward a write that lands on the entry being read in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ren) begin
			hit_q <= wen && (waddr == raddr);
		end
	end

	assign rdata = hit_q ? fwd_q : rd_q;
endmodule
`default_nettype wire

/* design/bb3_ctrl.sv */
`default_nettype none
module bb3_ctrl import bb3_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              accept,
	input  wire                              operation,
	input  wire                              restart,
	input  wire [$clog2(MAX_WIDTH+1)-1:0]    w,
	input  wire [$clog2(MAX_HEIGHT+1)-1:0]   h,
	output logic                             act,
	output logic                             blank,
	output logic [$clog2(MAX_WIDTH)-1:0]     addr,
	output tag_t                             tag
);
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH+1);
	localparam int HW = $clog2(MAX_HEIGHT+1);
	localparam int RW = $clog2(MAX_HEIGHT+2);

	logic [AW-1:0] qcol_q, pcol_q;
	logic [RW-1:0] qrow_q;
	logic [HW-1:0] prow_q;
	logic          primed, qcol_end, pcol_end, prow_end;

	always_comb begin
		blank    = qrow_q >= RW'(h);
		primed   = (qrow_q >= RW'(2)) || ((qrow_q == RW'(1)) && (qcol_q != '0));
		qcol_end = WW'(qcol_q) == (w - WW'(1));
		pcol_end = WW'(pcol_q) == (w - WW'(1));
		prow_end = prow_q == (h - HW'(1));
		act      = accept && (blank || (operation == OP_PUSH));
		addr     = qcol_q;
		tag.emit   = primed;
		tag.last   = primed && prow_end && pcol_end;
		tag.top    = prow_q != '0;
		tag.bottom = !prow_end;
		tag.left   = pcol_q != '0;
		tag.right  = !pcol_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qcol_q <= '0;
			qrow_q <= '0;
			pcol_q <= '0;
			prow_q <= '0;
		end else if (restart || (act && tag.last)) begin
			qcol_q <= '0;
			qrow_q <= '0;
			pcol_q <= '0;
			prow_q <= '0;
		end else if (act) begin
			if (qcol_end) begin
				qcol_q <= '0;
				qrow_q <= qrow_q + RW'(1);
			end else begin
				qcol_q <= qcol_q + AW'(1);
			end
			if (primed) begin
				if (pcol_end) begin
					pcol_q <= '0;
					prow_q <= prow_q + HW'(1);
				end else begin
					pcol_q <= pcol_q + AW'(1);
				end
			end
		end
	end
endmodule
`default_nettype wire

/* design/bb3_window.sv */
`default_nettype none
module bb3_window import bb3_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           act,
	input  wire [$clog2(MAX_WIDTH)-1:0]   addr,
	input  tag_t                          tag,
	input  wire [PIX_W-1:0]               pixel,
	input  wire [2*PIX_W-1:0]             mem_rdata,
	output logic                          mem_wen,
	output logic [$clog2(MAX_WIDTH)-1:0]  mem_waddr,
	output logic [2*PIX_W-1:0]            mem_wdata,
	output logic                          push,
	output res_t                          push_data
);
	localparam int AW = $clog2(MAX_WIDTH);

	logic             valid_s1, valid_s2, valid_s3;
	logic [AW-1:0]    addr_s1;
	tag_t             tag_s1, tag_s2;
	logic [PIX_W-1:0] pix_s1;
	logic [PIX_W-1:0] win_q [9];
	logic [SUM_W-1:0] sum_c [3];
	logic [SUM_W-1:0] sum_s3 [3];
	cnt_t             cnt_c, cnt_s3;
	logic             last_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			valid_s1 <= act;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2 && tag_s2.emit;
			if (valid_s1) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r*3]   <= win_q[r*3+1];
					win_q[r*3+1] <= win_q[r*3+2];
				end
				win_q[2] <= mem_rdata[2*PIX_W-1:PIX_W];
				win_q[5] <= mem_rdata[PIX_W-1:0];
				win_q[8] <= pix_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (act) begin
			addr_s1 <= addr;
			tag_s1  <= tag;
			pix_s1  <= pixel;
		end
		tag_s2 <= tag_s1;
		for (int ch = 0; ch < 3; ch++) begin
			sum_s3[ch] <= sum_c[ch];
		end
		cnt_s3  <= cnt_c;
		last_s3 <= tag_s2.last;
	end

	// Shift the middle row entry up and store the new pixel as middle.
	assign mem_wen   = valid_s1;
	assign mem_waddr = addr_s1;
	assign mem_wdata = {mem_rdata[PIX_W-1:0], pix_s1};

	always_comb begin
		logic rsel, csel;
		for (int ch = 0; ch < 3; ch++) begin
			sum_c[ch] = '0;
		end
		for (int r = 0; r < 3; r++) begin
			rsel = (r == 0) ? tag_s2.top : (r == 2) ? tag_s2.bottom : 1'b1;
			for (int c = 0; c < 3; c++) begin
				csel = (c == 0) ? tag_s2.left : (c == 2) ? tag_s2.right : 1'b1;
				if (rsel && csel) begin
					for (int ch = 0; ch < 3; ch++) begin
						sum_c[ch] = sum_c[ch] + SUM_W'(win_q[r*3+c][(2-ch)*8 +: 8]);
					end
				end
			end
		end
		if (tag_s2.top && tag_s2.bottom && tag_s2.left && tag_s2.right) begin
			cnt_c = CNT9;
		end else if ((tag_s2.top && tag_s2.bottom) || (tag_s2.left && tag_s2.right)) begin
			cnt_c = CNT6;
		end else begin
			cnt_c = CNT4;
		end
	end

	assign push            = valid_s3;
	assign push_data.red   = bb3_mean(sum_s3[0], cnt_s3);
	assign push_data.green = bb3_mean(sum_s3[1], cnt_s3);
	assign push_data.blue  = bb3_mean(sum_s3[2], cnt_s3);
	assign push_data.last  = last_s3;
endmodule
`default_nettype wire

/* design/bb3_out_fifo.sv */
`default_nettype none
module bb3_out_fifo import bb3_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  push,
	input  res_t push_data,
	input  wire  pop,
	output logic valid,
	output res_t head
);
	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH+1);

	res_t          buf_q [FIFO_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	assign valid = cnt_q != '0;
	assign head  = buf_q[rd_q];
endmodule
`default_nettype wire

/* design/bb3_checker.sv */
`default_nettype none
`include "box_blur_3x3_edge_aware_top_macros.svh"
module bb3_checker import bb3_pkg::*; (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  in_valid,
	input wire                  in_ready,
	input wire                  operation,
	input wire [7:0]            red_in,
	input wire [7:0]            green_in,
	input wire [7:0]            blue_in,
	input wire                  out_valid,
	input wire                  out_ready,
	input wire [7:0]            red_out,
	input wire [7:0]            green_out,
	input wire [7:0]            blue_out,
	input wire                  frame_last,
	input wire                  cfg_valid,
	input wire                  cfg_ready,
	input wire [CFG_IDX_W-1:0]  cfg_index,
	input wire [CFG_DATA_W-1:0] cfg_data
);
	`BB3_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "config write not taken")
	`BB3_ASSERT_NOW(a_stall_has_out, !in_ready, out_valid, "input stalled with no result")
	`BB3_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
	`BB3_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(red_out) && $stable(green_out) && $stable(blue_out) && $stable(frame_last), "stalled result changed")
endmodule

bind box_blur_3x3_edge_aware_top bb3_checker u_bb3_checker (.*);
`default_nettype wire

/* dv/box_blur_3x3_edge_aware_top_test.sv */
`default_nettype none
// Stream RGB frames through the blur, predict every blurred pixel
// in step with each accepted input transaction, and compare each
// output transaction field by field with the oldest pending
// prediction.
module box_blur_3x3_edge_aware_top_test;
	import bb3_pkg::*;

	localparam int LINE_LEN   = DEF_MAX_WIDTH;
	localparam int ROWS_MAX   = DEF_MAX_HEIGHT;
	localparam int SETTLE_CYC = 12;       // lets the pipeline run dry, with margin
	localparam int HOLD_CYC   = 80;       // long receiver hold-off
	localparam int CYCLE_CAP  = 600000;
	localparam int RAND_ITEMS = 550;

	// Indexes past the end of the register list; writes there must do nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} blur_px_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  operation = OP_PUSH;
	logic [7:0]            red_in = '0;
	logic [7:0]            green_in = '0;
	logic [7:0]            blue_in = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [7:0]            red_out;
	logic [7:0]            green_out;
	logic [7:0]            blue_out;
	logic                  frame_last;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	box_blur_3x3_edge_aware_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .operation(operation),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.frame_last(frame_last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Shadow of the blur state.
	logic [23:0]  upper_line [LINE_LEN];
	logic [23:0]  middle_line [LINE_LEN];
	logic [23:0]  win [9];
	logic [10:0]  width_reg;
	logic [12:0]  height_reg;
	int unsigned  pix_pos;
	blur_px_t     expected_px [$];

	int  fail_count = 0;
	int  cycle_count = 0;
	bit  quiet = 1'b0;       // no idling on either side in the closing part
	bit  hold_req = 1'b0;    // ask the receiver for one long hold-off
	int  rx_stall = 0;

	function automatic int unsigned active_width();
		if (width_reg < 2) return 2;
		if (width_reg > LINE_LEN) return LINE_LEN;
		return width_reg;
	endfunction

	function automatic int unsigned active_height();
		if (height_reg < 2) return 2;
		if (height_reg > ROWS_MAX) return ROWS_MAX;
		return height_reg;
	endfunction

	// Rounded (half up) mean of one channel over the in-frame window cells.
	function automatic logic [7:0] neighborhood_mean(int sh, bit t, bit b, bit l, bit r);
		int unsigned sum;
		int unsigned cnt;
		sum = 0;
		cnt = 0;
		for (int row = 0; row < 3; row++) begin
			if ((row == 0 && !t) || (row == 2 && !b)) continue;
			for (int col = 0; col < 3; col++) begin
				if ((col == 0 && !l) || (col == 2 && !r)) continue;
				sum += (win[row*3+col] >> sh) & 8'hFF;
				cnt++;
			end
		end
		return 8'((2*sum + cnt) / (2*cnt));
	endfunction

	// Advance the shadow state by one accepted transaction.
	task automatic predict_blur(input logic op, input logic [23:0] pix_in);
		int unsigned w, h, total, q, qc, p, pr, pc;
		logic [23:0] pix;
		blur_px_t px;
		bit t, b, l, r;
		w = active_width();
		h = active_height();
		total = w * h;
		q = pix_pos;
		// early flush: dropped without effect
		if (q < total && op == OP_FLUSH) return;
		// past the frame any transaction drains, pixel value discarded
		pix = (q >= total) ? 24'h0 : pix_in;
		qc = q % w;
		for (int row = 0; row < 3; row++) begin
			win[row*3] = win[row*3+1];
			win[row*3+1] = win[row*3+2];
		end
		win[2] = upper_line[qc];
		win[5] = middle_line[qc];
		win[8] = pix;
		upper_line[qc] = middle_line[qc];
		middle_line[qc] = pix;
		pix_pos = q + 1;
		if (q < w + 1) return;
		p = q - w - 1;
		pr = p / w;
		pc = p % w;
		t = pr != 0;
		b = pr + 1 < h;
		l = pc != 0;
		r = pc + 1 < w;
		px.red = neighborhood_mean(16, t, b, l, r);
		px.green = neighborhood_mean(8, t, b, l, r);
		px.blue = neighborhood_mean(0, t, b, l, r);
		px.last = p + 1 >= total;
		expected_px.push_back(px);
		if (px.last) pix_pos = 0;
	endtask

	function automatic logic [7:0] rand_chan();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Offer one transaction and hold it until the block takes it.
	// Valid stays high on return so a following call can chain.
	task automatic send_pixel(input logic op, input logic [7:0] r, g, b);
		in_valid <= 1'b1;
		operation <= op;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_blur(op, {r, g, b});
	endtask

	// Occasional random gap on the input side.
	task automatic maybe_gap();
		if (quiet || $urandom_range(0, 9) != 0) return;
		in_valid <= 1'b0;
		repeat ($urandom_range(1, 13)) @(posedge clk);
	endtask

	// Drop valid and wait until every prediction is matched, then let the
	// pipeline run dry since transactions that produce no result may still be in flight.
	task automatic drain_wait();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_px.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_FRAME_WIDTH) begin
			width_reg = val[10:0];
			pix_pos = 0;
		end else if (idx == REG_FRAME_HEIGHT) begin
			height_reg = val;
			pix_pos = 0;
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Push n pixels; with noise, sprinkle early flushes and gaps.
	task automatic push_pixels(input int n, input bit noisy);
		for (int i = 0; i < n; i++) begin
			if (noisy && $urandom_range(0, 9) == 0)
				send_pixel(OP_FLUSH, rand_chan(), rand_chan(), rand_chan());
			send_pixel(OP_PUSH, rand_chan(), rand_chan(), rand_chan());
			if (noisy) maybe_gap();
		end
	endtask

	// Drain the trailing outputs; with noise, some drain items are pixels.
	task automatic drain_frame(input bit noisy);
		int n;
		logic op;
		n = active_width() + 1;
		for (int i = 0; i < n; i++) begin
			op = (noisy && $urandom_range(0, 2) == 0) ? OP_PUSH : OP_FLUSH;
			send_pixel(op, rand_chan(), rand_chan(), rand_chan());
			if (noisy) maybe_gap();
		end
	endtask

	task automatic full_frame(input bit noisy);
		push_pixels(active_width() * active_height(), noisy);
		drain_frame(noisy);
	endtask

	// Compare each output transaction with the oldest prediction, and
	// drive out_ready with random stalls or one long hold-off.
	always @(posedge clk) begin
		blur_px_t want;
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("Test completed with failures");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_px.size() == 0) begin
				$error("output transaction with nothing expected");
				fail_count++;
			end else begin
				want = expected_px.pop_front();
				if (red_out !== want.red) begin
					$error("red_out expected %0d actual %0d", want.red, red_out);
					fail_count++;
				end
				if (green_out !== want.green) begin
					$error("green_out expected %0d actual %0d", want.green, green_out);
					fail_count++;
				end
				if (blue_out !== want.blue) begin
					$error("blue_out expected %0d actual %0d", want.blue, blue_out);
					fail_count++;
				end
				if (frame_last !== want.last) begin
					$error("frame_last expected %0b actual %0b", want.last, frame_last);
					fail_count++;
				end
			end
		end
		if (rx_stall > 0) begin
			rx_stall--;
			out_ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			rx_stall = HOLD_CYC - 1;
			out_ready <= 1'b0;
		end else if (!quiet && arst_n && $urandom_range(0, 7) == 0) begin
			rx_stall = $urandom_range(0, 12);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Out-of-range register values clamp; upper width bits are dropped.
	task automatic test_register_clamps();
		write_reg(REG_FRAME_WIDTH, 13'd0);
		write_reg(REG_FRAME_HEIGHT, 13'd0);
		full_frame(1'b0);
		drain_wait();
		write_reg(REG_FRAME_WIDTH, 13'h0803);
		write_reg(REG_FRAME_HEIGHT, 13'd1);
		full_frame(1'b0);
		drain_wait();
		// tall frame: only the first rows are pushed, then abandoned
		write_reg(REG_FRAME_WIDTH, 13'd0);
		write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
		push_pixels(12, 1'b0);
		drain_wait();
	endtask

	// Early flushes, pixels past the frame, spare indexes, restart on write.
	task automatic test_frame_controls();
		write_reg(REG_FRAME_WIDTH, 13'd3);
		write_reg(REG_FRAME_HEIGHT, 13'd3);
		send_pixel(OP_FLUSH, 8'hFF, 8'hFF, 8'hFF);
		push_pixels(5, 1'b0);
		drain_wait();
		// spare index mid-frame must leave the position alone
		write_reg(REG_SPARE_A, 13'h1FFF);
		write_reg(REG_SPARE_B, 13'h0000);
		push_pixels(4, 1'b0);
		for (int i = 0; i < 4; i++) send_pixel(OP_PUSH, 8'hAA, 8'h55, 8'h0F);
		// next frame follows directly after frame_last
		full_frame(1'b0);
		push_pixels(7, 1'b0);
		drain_wait();
		// a register write restarts the frame
		write_reg(REG_FRAME_WIDTH, 13'd2);
		full_frame(1'b0);
		drain_wait();
	endtask

	// Hold off the receiver while the sender keeps offering pixels.
	task automatic test_backpressure();
		write_reg(REG_FRAME_WIDTH, 13'd4);
		write_reg(REG_FRAME_HEIGHT, 13'd8);
		hold_req = 1'b1;
		full_frame(1'b0);
		drain_wait();
	endtask

	// Random small frames, some abandoned partway, until enough items ran.
	task automatic random_frames(input int budget);
		int done;
		int w, h, n;
		done = 0;
		while (done < budget) begin
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 24) : $urandom_range(2, 6);
			h = $urandom_range(2, 5);
			if ($urandom_range(0, 1)) begin
				write_reg(REG_FRAME_WIDTH, 13'(w) | (13'($urandom_range(0, 3)) << 11));
				write_reg(REG_FRAME_HEIGHT, 13'(h));
			end else begin
				write_reg(REG_FRAME_HEIGHT, 13'(h));
				write_reg(REG_FRAME_WIDTH, 13'(w));
			end
			if ($urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, w * h - 1);
				push_pixels(n, 1'b1);
				done += n;
			end else begin
				repeat ($urandom_range(1, 2)) begin
					full_frame(1'b1);
					done += w * h + w + 1;
				end
			end
			drain_wait();
		end
	endtask

	task automatic test_random();
		random_frames(RAND_ITEMS);
	endtask

	task automatic test_quiet_tail();
		quiet = 1'b1;
		random_frames(150);
	endtask

	initial begin
		width_reg = 11'(RST_WIDTH);
		height_reg = 13'(RST_HEIGHT);
		pix_pos = 0;
		for (int i = 0; i < 9; i++) win[i] = '0;
		for (int i = 0; i < LINE_LEN; i++) begin
			upper_line[i] = '0;
			middle_line[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_clamps();
		test_frame_controls();
		test_backpressure();
		test_random();
		test_quiet_tail();
		if (fail_count == 0 && expected_px.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire

/* sim.f */
+incdir+design
design/bb3_pkg.sv
design/bb3_line_buf.sv
design/bb3_ctrl.sv
design/bb3_window.sv
design/bb3_out_fifo.sv
design/box_blur_3x3_edge_aware_top.sv
design/bb3_checker.sv
dv/box_blur_3x3_edge_aware_top_test.sv
